### hw/rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants of the insertion sorter
// Data width, store depth, beat structs and per-cell control.
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         set_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         run_end;
      logic                         overflow;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic insert;  // place new value this cycle
      logic drain;   // shift everything one cell towards the head
   } cell_ctrl_type;

   // what a cell shows to its neighbours
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         valid;
      logic                         lt;     // new value sorts before this entry
   } cell_link_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

### hw/rtl/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell: one entry of the systolic sorting chain
// Holds one value; on insert it keeps, takes the new value or takes the
// left neighbour's; on drain it takes the right neighbour's.
// ----------------------------------------------------------------------------
module isort_cell import isort_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [DATA_WIDTH-1:0]  new_value,
   input  cell_link_type                 prev_link,
   input  cell_link_type                 next_link,
   output cell_link_type                 link
);

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         lt;

   assign lt = valid_ff && (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.drain) begin
         value_in = next_link.value;
         valid_in = next_link.valid;
      end else if (ctrl.insert) begin
         valid_in = valid_ff || prev_link.valid;
         if (prev_link.lt) begin
            value_in = prev_link.value;
         end else if (lt || (!valid_ff && prev_link.valid)) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.lt    = lt;

endmodule

### hw/rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter: streaming insertion sort over sets of signed values
// Systolic chain of DEPTH cells; sorted run is drained from the head.
// ----------------------------------------------------------------------------
// Usage: present one signed value per beat on req_data with start high; a
// beat is taken on any edge where start is high and busy is low. While a set
// is being filled busy stays low, so one value goes in every clock: every cell
// compares the new value in parallel and the chain opens a gap at the
// insertion point. Values beyond DEPTH are dropped and the whole run is then
// flagged with overflow. The beat carrying set_end is inserted first; from
// the next cycle busy stays high until all stored values (1..DEPTH) have
// left, and in each drain cycle rsp_strobe is high for one cycle with the
// next value in ascending order, taken from the head cell while the chain
// shifts one place. The receiver cannot stall: every strobed beat must be
// consumed in that cycle. run_end marks the last beat of the run; busy falls
// in the cycle after it, and a new set can start once it has fallen. Equal
// values leave in arrival order.
// ----------------------------------------------------------------------------
module insertion_sorter import isort_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type     state_ff, state_in;
   logic          dropped_ff, dropped_in;
   logic          accept;
   logic          full;
   logic          last_beat;
   cell_ctrl_type ctrl;
   cell_link_type links [DEPTH];

   // chain is full when its tail cell holds a value
   assign full   = links[DEPTH-1].valid;
   assign accept = start && !busy;

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = (state_ff == ST_DRAIN);

   // head cell is the only one left: this beat closes the run
   assign last_beat = ctrl.drain && !links[1].valid;

   // ---- the cell chain ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type prev_link, next_link;

      if (i == 0) begin : g_head
         // virtual left neighbour: always occupied, never shifting
         assign prev_link.value = '0;
         assign prev_link.valid = 1'b1;
         assign prev_link.lt    = 1'b0;
      end else begin : g_body
         assign prev_link = links[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         // nothing to the right: drain shifts in an empty slot
         assign next_link.value = '0;
         assign next_link.valid = 1'b0;
         assign next_link.lt    = 1'b0;
      end else begin : g_mid
         assign next_link = links[i+1];
      end

      isort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (req_data.value),
         .prev_link (prev_link),
         .next_link (next_link),
         .link      (links[i])
      );
   end

   // ---- sequencing: fill, then drain ----
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               dropped_in = dropped_ff || full;  // set_end beat may drop too
               if (req_data.set_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (last_beat) begin
               state_in   = ST_FILL;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in   = ST_FILL;
            dropped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign busy = (state_ff == ST_DRAIN);

   // result beats come straight from the head cell
   assign rsp_strobe            = ctrl.drain && links[0].valid;
   assign rsp_data.sorted_value = links[0].value;
   assign rsp_data.run_end      = last_beat;
   assign rsp_data.overflow     = dropped_ff;

`ifndef SYNTHESIS
   // a set_end beat always starts a drain
   a_end_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.set_end) |=> busy)
      else $error("set_end beat did not start the drain");

   // during a drain the head never runs dry before run_end
   a_drain_no_gap: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_strobe)
      else $error("drain cycle without a result beat");

   // the drain stops right after the final beat
   a_end_releases: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.run_end) |=> !busy)
      else $error("busy held after the final beat");

   // the chain is never empty while draining
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_data.run_end) |-> links[1].valid)
      else $error("chain emptied without run_end");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the insertion sorter
// Feeds sets of signed values through the command port, predicts each sorted
// run with a shadow store and checks every strobed result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
   import isort_pkg::*;

   localparam int IDLE_LIMIT  = 2000;  // cycles with no beat either way
   localparam int RAND_ITEMS  = 86;
   localparam int SETTLE_CYC  = DEPTH + 4;

   // one pending input beat plus how the sender treats it
   typedef struct {
      req_type     beat;
      int unsigned idle_pct;  // chance of an idle cycle before presenting it
      bit          hold;      // wait for every due result before presenting
   } feed_item_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   feed_item_type feed_queue[$];
   rsp_type       sorted_due[$];       // results still owed by the block

   // shadow copy of the sorting store
   logic signed [DATA_WIDTH-1:0] shadow_store[DEPTH];
   int  shadow_fill    = 0;
   bit  shadow_dropped = 1'b0;

   int  beats_in     = 0;  // beats taken by the block
   int  beats_shown  = 0;  // beats put on the port by the driver
   int  idle_cycles  = 0;
   int  total_items  = 0;
   bit  failed       = 1'b0;

   insertion_sorter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: insert after every entry that is less than or equal to the
   // new one (strict less-than walk), so equal values keep arrival order.
   // A full store drops the value and flags the whole run.
   // ---------------------------------------------------------------------
   task automatic sort_in(input req_type beat);
      int      pos;
      rsp_type due;
      begin
         if (shadow_fill >= DEPTH) begin
            shadow_dropped = 1'b1;
         end else begin
            pos = shadow_fill;
            while (pos > 0 && beat.value < shadow_store[pos-1])
               pos--;
            for (int i = shadow_fill; i > pos; i--)
               shadow_store[i] = shadow_store[i-1];
            shadow_store[pos] = beat.value;
            shadow_fill++;
         end
         if (beat.set_end) begin
            // set closed: the whole run falls due, last one marked
            for (int k = 0; k < shadow_fill; k++) begin
               due.sorted_value = shadow_store[k];
               due.run_end      = (k == shadow_fill - 1);
               due.overflow     = shadow_dropped;
               sorted_due.push_back(due);
            end
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
         end
      end
   endtask

   task automatic check_sorted(input rsp_type got);
      rsp_type want;
      begin
         if (sorted_due.size() == 0) begin
            $error("result beat with nothing due: sorted_value %0d", got.sorted_value);
            failed = 1'b1;
         end else begin
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, got.sorted_value);
               failed = 1'b1;
            end
            if (got.run_end !== want.run_end) begin
               $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
               failed = 1'b1;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
               failed = 1'b1;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_value(input logic signed [DATA_WIDTH-1:0] v, input bit last,
                              input int unsigned idle_pct, input bit hold);
      feed_item_type item;
      begin
         item.beat.value   = v;
         item.beat.set_end = last;
         item.idle_pct     = idle_pct;
         item.hold         = hold;
         feed_queue.push_back(item);
      end
   endtask

   // half full-range values, the rest clusters that force ties and extremes
   function automatic logic signed [DATA_WIDTH-1:0] pick_value(
         input logic signed [DATA_WIDTH-1:0] prev);
      logic signed [DATA_WIDTH-1:0] v;
      begin
         case ($urandom_range(9))
            5: v = $signed($urandom_range(8)) - 4;
            6: v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            7: v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            8: v = $urandom_range(1) ? '1 : '0;
            9: v = prev;
            default: v = $urandom;
         endcase
         return v;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: new beat only once the current one is gone; idles at random.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      feed_item_type nxt;
      bit            go;
      if (!reset && (!start || beats_in == beats_shown)) begin
         go = 1'b0;
         if (feed_queue.size() > 0 &&
             !(feed_queue[0].hold && sorted_due.size() != 0) &&
             $urandom_range(99) >= feed_queue[0].idle_pct) begin
            nxt = feed_queue.pop_front();
            go  = 1'b1;
            beats_shown++;
         end
         start <= go;
         if (go)
            req_data <= nxt.beat;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each taken beat, check each strobed result beat.
   // Results never arrive in the cycle of their set_end, so prediction
   // always runs ahead of checking.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sort_in(req_data);
            beats_in++;
         end
         if (rsp_strobe)
            check_sorted(rsp_data);
      end
   end

   // watchdog: a stalled handshake ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic signed [DATA_WIDTH-1:0] prev_v;
      int          rand_count;
      int          set_len;
      int          r;
      int          phase;
      int unsigned idle_pct;
      int unsigned idle_by_phase[4];
      bit          phase_start;

      idle_by_phase = '{0, 72, 0, 19};

      // directed: single-value sets at both extremes
      queue_value({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b1, 0, 1'b0);
      queue_value({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b1, 0, 1'b0);
      // mixed signs, extremes and a tie on the closing beat
      queue_value(0, 1'b0, 0, 1'b0);
      queue_value(-1, 1'b0, 0, 1'b0);
      queue_value({1'b0, {(DATA_WIDTH-1){1'b1}}}, 1'b0, 0, 1'b0);
      queue_value({1'b1, {(DATA_WIDTH-1){1'b0}}}, 1'b0, 0, 1'b0);
      queue_value(-1, 1'b1, 0, 1'b0);
      // store overflow: 17 values, the dropped one carries set_end
      for (int i = 0; i < DEPTH + 1; i++)
         queue_value(DEPTH / 2 - i, i == DEPTH, 0, i == 0);

      // random sets in four idling phases
      rand_count = 0;
      prev_v     = 0;
      while (rand_count < RAND_ITEMS) begin
         r = $urandom_range(19);
         if (r < 2)
            set_len = DEPTH + 1 + $urandom_range(3);
         else if (r < 4)
            set_len = DEPTH;
         else if (r < 8)
            set_len = $urandom_range(3, 1);
         else
            set_len = $urandom_range(DEPTH - 1, 1);
         for (int i = 0; i < set_len; i++) begin
            // the last set may run past RAND_ITEMS: it stays in the last phase
            phase = (rand_count * 4) / RAND_ITEMS;
            if (phase > 3)
               phase = 3;
            idle_pct    = idle_by_phase[phase];
            phase_start = (rand_count % (RAND_ITEMS / 4)) == 0;
            prev_v      = pick_value(prev_v);
            queue_value(prev_v, i == set_len - 1, idle_pct, phase_start);
            rand_count++;
         end
      end
      total_items = feed_queue.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (beats_in == total_items);
      wait (sorted_due.size() == 0);
      repeat (SETTLE_CYC) @(posedge clock);

      if (failed)
         $display("tb_top: FAIL");
      else
         $display("tb_top: PASS");
      $finish;
   end

endmodule
